// ----- design/two_link_arm_inverse_kinematics_assert.svh -----
// Assertion macros used by the top-level design file.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IKIN_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ikin: implication check failed");

// The consequent must hold after the antecedent, delayed by the lat argument.
`define IKIN_ASSERT_AFTER(label, ante, lat, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##lat (cons)) \
    else $error("ikin: latency check failed");

`endif

// ----- design/ikin_pkg.sv -----
package ikin_pkg;

  localparam int CW = 44;
  localparam int MW = 40;
  localparam int ZW = 32;
  localparam int TABLE_DEPTH = 24;
  localparam int NORM_STEPS = 6;
  localparam int ROOT_CELLS = 32;
  localparam int QW = 64;

  localparam logic [ZW-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ZW-1:0] THREE_QUARTER_TURN = 32'hC000_0000;
  localparam logic [ZW-1:0] ROUND_HALF = 32'h0000_8000;
  localparam logic [15:0] HALF_TURN = 16'h8000;

  localparam logic [1:0] REG_FIRST_LINK = 2'd0;
  localparam logic [1:0] REG_SECOND_LINK = 2'd1;

  localparam logic [ZW-1:0] ATAN_TABLE [0:TABLE_DEPTH-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    SOL_NONE = 2'd0,
    SOL_ONE  = 2'd1,
    SOL_TWO  = 2'd2
  } sol_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [QW-1:0] v;
    logic [QW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [33:0] ub;
    logic signed [33:0] uc;
    sol_t               cls;
  } side_t;

endpackage

// ----- design/ikin_sqrt_cell.sv -----
module ikin_sqrt_cell
  import ikin_pkg::*;
#(
  parameter int K = 0
) (
  input  logic  clk,
  input  sqrt_t din,
  output sqrt_t dout
);

  localparam logic [QW-1:0] BIT = 64'd1 << (62 - 2 * K);

  logic [QW-1:0] trial;
  sqrt_t         dout_next;

  always_comb begin
    trial = din.res + BIT;
    if (din.v >= trial) begin
      dout_next.v = din.v - trial;
      dout_next.res = (din.res >> 1) + BIT;
    end else begin
      dout_next.v = din.v;
      dout_next.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

// ----- design/ikin_cordic_cell.sv -----
module ikin_cordic_cell
  import ikin_pkg::*;
#(
  parameter int I = 0
) (
  input  logic    clk,
  input  cordic_t din,
  output cordic_t dout
);

  localparam logic [ZW-1:0] STEP = ATAN_TABLE[I];

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  cordic_t              dout_next;

  always_comb begin
    dx = din.y >>> I;
    dy = din.x >>> I;
    dout_next.zero = din.zero;
    if (!din.y[CW-1]) begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + STEP;
    end else begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - STEP;
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

// ----- design/ikin_cordic.sv -----
module ikin_cordic
  import ikin_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic [15:0]          angle
);

  cordic_t       quarter_next;
  logic [CW-1:0] ax;
  logic [CW-1:0] ay;
  logic [MW-1:0] m_next;
  cordic_t       nrm [0:NORM_STEPS];
  logic [MW-1:0] nm [0:NORM_STEPS];
  cordic_t       st [0:STAGES];
  logic [ZW-1:0] z_round;

  always_comb begin
    quarter_next.zero = (x_in == '0) && (y_in == '0);
    quarter_next.x = x_in;
    quarter_next.y = y_in;
    quarter_next.z = '0;
    if (x_in[CW-1]) begin
      if (!y_in[CW-1]) begin
        quarter_next.x = y_in;
        quarter_next.y = -x_in;
        quarter_next.z = QUARTER_TURN;
      end else begin
        quarter_next.x = -y_in;
        quarter_next.y = x_in;
        quarter_next.z = THREE_QUARTER_TURN;
      end
    end
    ax = quarter_next.x[CW-1] ? -quarter_next.x : quarter_next.x;
    ay = quarter_next.y[CW-1] ? -quarter_next.y : quarter_next.y;
    m_next = (ax > ay) ? ax[MW-1:0] : ay[MW-1:0];
  end

  always_ff @(posedge clk) begin
    nrm[0] <= quarter_next;
    nm[0] <= m_next;
  end

  for (genvar s = 0; s < NORM_STEPS; s++) begin : g_norm
    localparam int SH = 32 >> s;
    always_ff @(posedge clk) begin
      if (nm[s][MW-1 -: SH] == '0) begin
        nrm[s+1].x <= nrm[s].x <<< SH;
        nrm[s+1].y <= nrm[s].y <<< SH;
        nm[s+1] <= nm[s] << SH;
      end else begin
        nrm[s+1].x <= nrm[s].x;
        nrm[s+1].y <= nrm[s].y;
        nm[s+1] <= nm[s];
      end
      nrm[s+1].z <= nrm[s].z;
      nrm[s+1].zero <= nrm[s].zero;
    end
  end

  assign st[0] = nrm[NORM_STEPS];

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    ikin_cordic_cell #(.I(i)) u_cell (
      .clk  (clk),
      .din  (st[i]),
      .dout (st[i+1])
    );
  end

  assign z_round = st[STAGES].z + ROUND_HALF;

  always_ff @(posedge clk) begin
    angle <= st[STAGES].zero ? 16'd0 : z_round[ZW-1:16];
  end

endmodule

// ----- design/two_link_arm_inverse_kinematics.sv -----
// Channel  Ports                                        Handshake
// input    target_x, target_y                           start && !busy
// config   cfg_index, cfg_data                          cfg_valid && cfg_ready
// result   solution_count, first/second shoulder/elbow  done, one cycle
//
// One item is taken every cycle; busy is never raised and cfg_ready is always high.
// Each result leaves in order, after its item has passed the 32-cell square root chain
// and the CORDIC angle chain that follows it.
// Reset clears the pipeline valid bits and sets both link lengths to 1.0.
// The receiver cannot stall; results stream out at the input rate.
`include "two_link_arm_inverse_kinematics_assert.svh"

module two_link_arm_inverse_kinematics
  import ikin_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic [1:0]         solution_count,
  output logic [15:0]        first_shoulder_angle,
  output logic [15:0]        first_elbow_angle,
  output logic [15:0]        second_shoulder_angle,
  output logic [15:0]        second_elbow_angle
);

  localparam int NSTG = (CORDIC_STAGES < TABLE_DEPTH) ? CORDIC_STAGES : TABLE_DEPTH;
  localparam int CLAT = NSTG + 8;
  localparam int SIDE_LAT = ROOT_CELLS + 1;
  localparam int TOTAL = 4 + ROOT_CELLS + CLAT + 1;

  logic [14:0] first_link_length;
  logic [14:0] second_link_length;
  logic [TOTAL-1:0] vld;

  logic signed [15:0] tx1;
  logic signed [15:0] ty1;

  logic signed [31:0] xx_full;
  logic signed [31:0] yy_full;
  logic [15:0] s_sum;
  logic [14:0] t_diff;
  logic signed [15:0] tx2;
  logic signed [15:0] ty2;
  logic [30:0] xx2;
  logic [30:0] yy2;
  logic [29:0] l1sq2;
  logic [29:0] l2sq2;
  logic [31:0] ssq2;
  logic [29:0] tsq2;

  logic [31:0] d2;
  sol_t        cls_next;
  side_t       side3;
  logic [31:0] f1;
  logic [31:0] f2;

  sqrt_t root_chain [0:ROOT_CELLS];
  side_t side_dly [0:SIDE_LAT-1];
  sol_t  cls_dly [0:CLAT-1];

  logic [15:0] ang_a;
  logic [15:0] ang_b;
  logic [15:0] ang_c;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_link_length <= 15'd256;
      second_link_length <= 15'd256;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FIRST_LINK) begin
        first_link_length <= cfg_data[14:0];
      end else if (cfg_index == REG_SECOND_LINK) begin
        second_link_length <= cfg_data[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    tx1 <= target_x;
    ty1 <= target_y;
  end

  always_comb begin
    xx_full = tx1 * tx1;
    yy_full = ty1 * ty1;
    s_sum = {1'b0, first_link_length} + {1'b0, second_link_length};
    t_diff = (first_link_length > second_link_length) ?
             first_link_length - second_link_length :
             second_link_length - first_link_length;
  end

  always_ff @(posedge clk) begin
    tx2 <= tx1;
    ty2 <= ty1;
    xx2 <= xx_full[30:0];
    yy2 <= yy_full[30:0];
    l1sq2 <= first_link_length * first_link_length;
    l2sq2 <= second_link_length * second_link_length;
    ssq2 <= s_sum * s_sum;
    tsq2 <= t_diff * t_diff;
  end

  always_comb begin
    d2 = {1'b0, xx2} + {1'b0, yy2};
    priority if (d2 == '0 || d2 > ssq2 || d2 < {2'b00, tsq2}) begin
      cls_next = SOL_NONE;
    end else if (d2 == ssq2) begin
      cls_next = SOL_ONE;
    end else begin
      cls_next = SOL_TWO;
    end
  end

  always_ff @(posedge clk) begin
    side3.tx <= tx2;
    side3.ty <= ty2;
    side3.ub <= $signed({4'b0, l1sq2}) + $signed({2'b0, d2}) - $signed({4'b0, l2sq2});
    side3.uc <= $signed({4'b0, l1sq2}) + $signed({4'b0, l2sq2}) - $signed({2'b0, d2});
    side3.cls <= cls_next;
    f1 <= ssq2 - d2;
    f2 <= d2 - {2'b00, tsq2};
  end

  always_ff @(posedge clk) begin
    root_chain[0].v <= f1 * f2;
    root_chain[0].res <= '0;
    side_dly[0] <= side3;
  end

  for (genvar k = 0; k < ROOT_CELLS; k++) begin : g_root
    ikin_sqrt_cell #(.K(k)) u_cell (
      .clk  (clk),
      .din  (root_chain[k]),
      .dout (root_chain[k+1])
    );
  end

  for (genvar j = 1; j < SIDE_LAT; j++) begin : g_side
    always_ff @(posedge clk) begin
      side_dly[j] <= side_dly[j-1];
    end
  end

  ikin_cordic #(.STAGES(NSTG)) u_cordic_a (
    .clk   (clk),
    .x_in  (CW'(side_dly[SIDE_LAT-1].tx)),
    .y_in  (CW'(side_dly[SIDE_LAT-1].ty)),
    .angle (ang_a)
  );

  ikin_cordic #(.STAGES(NSTG)) u_cordic_b (
    .clk   (clk),
    .x_in  (CW'(side_dly[SIDE_LAT-1].ub)),
    .y_in  ($signed({12'b0, root_chain[ROOT_CELLS].res[31:0]})),
    .angle (ang_b)
  );

  ikin_cordic #(.STAGES(NSTG)) u_cordic_c (
    .clk   (clk),
    .x_in  (CW'(side_dly[SIDE_LAT-1].uc)),
    .y_in  ($signed({12'b0, root_chain[ROOT_CELLS].res[31:0]})),
    .angle (ang_c)
  );

  always_ff @(posedge clk) begin
    cls_dly[0] <= side_dly[SIDE_LAT-1].cls;
  end

  for (genvar j = 1; j < CLAT; j++) begin : g_cls
    always_ff @(posedge clk) begin
      cls_dly[j] <= cls_dly[j-1];
    end
  end

  always_ff @(posedge clk) begin
    solution_count <= cls_dly[CLAT-1];
    unique case (cls_dly[CLAT-1])
      SOL_TWO: begin
        first_shoulder_angle <= ang_a + ang_b;
        first_elbow_angle <= HALF_TURN + ang_c;
        second_shoulder_angle <= ang_a - ang_b;
        second_elbow_angle <= HALF_TURN - ang_c;
      end
      SOL_ONE: begin
        first_shoulder_angle <= ang_a;
        first_elbow_angle <= '0;
        second_shoulder_angle <= '0;
        second_elbow_angle <= '0;
      end
      default: begin
        first_shoulder_angle <= '0;
        first_elbow_angle <= '0;
        second_shoulder_angle <= '0;
        second_elbow_angle <= '0;
      end
    endcase
  end

  assign done = vld[TOTAL-1];

  `IKIN_ASSERT_AFTER(a_latency, start && !busy, TOTAL, done)
  `IKIN_ASSERT_IMPLIES(a_none_zero, done && solution_count == SOL_NONE,
    first_shoulder_angle == '0 && first_elbow_angle == '0 && second_elbow_angle == '0)
  `IKIN_ASSERT_IMPLIES(a_one_shape, done && solution_count == SOL_ONE,
    first_elbow_angle == '0 && second_shoulder_angle == '0 && second_elbow_angle == '0)

endmodule
